[hw/rtl/button_debounce_press_classifier_core_assert.svh]
// Assertion macros for the button debounce and press classifier.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_ASSERT_SVH

`ifndef SYNTH
`define BDPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define BDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BDPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/bdpc_pkg.sv]
// Shared types and constants of the button debounce and press classifier.
package bdpc_pkg;

  localparam int unsigned AgeWidthDef = 16;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgWidth-1:0] DebounceTicksRst = 16'd15;
  localparam logic [CfgWidth-1:0] ShortMaxTicksRst = 16'd1000;
  localparam logic [CfgWidth-1:0] LongTicksRst     = 16'd3000;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DEBOUNCE_TICKS  = 2'd0,
    CFG_SHORT_MAX_TICKS = 2'd1,
    CFG_LONG_TICKS      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ticks;
    logic [CfgWidth-1:0] short_max_ticks;
    logic [CfgWidth-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic stable_out;
    logic press_event;
    logic release_event;
    logic short_event;
    logic long_event;
  } result_t;

endpackage

[hw/rtl/bdpc_cfg.sv]
// Configuration register file of the button debounce and press classifier.
module bdpc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bdpc_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [bdpc_pkg::CfgWidth-1:0]    cfg_data_i,
  output bdpc_pkg::cfg_t                cfg_o
);
  import bdpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DEBOUNCE_TICKS:  cfg_d.debounce_ticks  = cfg_data_i;
        CFG_SHORT_MAX_TICKS: cfg_d.short_max_ticks = cfg_data_i;
        CFG_LONG_TICKS:      cfg_d.long_ticks      = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks  <= DebounceTicksRst;
      cfg_q.short_max_ticks <= ShortMaxTicksRst;
      cfg_q.long_ticks      <= LongTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/bdpc_track.sv]
// Debounce and press tracking state with its per-tick update logic.
module bdpc_track #(
  parameter int unsigned AGE_WIDTH = bdpc_pkg::AgeWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              pin_i,
  input  bdpc_pkg::cfg_t    cfg_i,
  output bdpc_pkg::result_t res_o
);
  import bdpc_pkg::*;

  localparam int unsigned CmpWidth = (AGE_WIDTH > CfgWidth) ? AGE_WIDTH : CfgWidth;
  localparam logic [AGE_WIDTH-1:0] AgeMax = {AGE_WIDTH{1'b1}};

  logic                 raw_q, raw_d;
  logic                 active_q, active_d;
  logic [AGE_WIDTH-1:0] dage_q, dage_d;
  logic                 stable_q, stable_d;
  logic [AGE_WIDTH-1:0] page_q, page_d;
  logic                 armed_q, armed_d;

  logic [AGE_WIDTH-1:0] dage_inc, page_inc;
  logic                 changed, active_n, settle, edge_seen, rise, fall, armed_n, long_hit;
  logic [CmpWidth-1:0]  dage_cmp, page_inc_cmp, page_cmp;
  logic [CmpWidth-1:0]  deb_cmp, short_cmp, long_cmp;

  always_comb begin
    dage_inc = (dage_q == AgeMax) ? dage_q : dage_q + AGE_WIDTH'(1);
    page_inc = (page_q == AgeMax) ? page_q : page_q + AGE_WIDTH'(1);

    changed  = pin_i != raw_q;
    raw_d    = pin_i;
    active_n = changed | active_q;
    dage_d   = changed ? '0 : dage_inc;

    dage_cmp  = CmpWidth'(dage_d);
    deb_cmp   = CmpWidth'(cfg_i.debounce_ticks);
    short_cmp = CmpWidth'(cfg_i.short_max_ticks);
    long_cmp  = CmpWidth'(cfg_i.long_ticks);

    settle    = active_n && (dage_cmp >= deb_cmp);
    active_d  = active_n & ~settle;
    edge_seen = settle && (raw_d != stable_q);
    rise      = edge_seen & raw_d;
    fall      = edge_seen & ~raw_d;
    stable_d  = edge_seen ? raw_d : stable_q;

    page_inc_cmp = CmpWidth'(page_inc);
    page_d       = rise ? '0 : page_inc;
    page_cmp     = CmpWidth'(page_d);

    armed_n  = rise ? 1'b1 : (fall ? 1'b0 : armed_q);
    long_hit = armed_n && (page_cmp >= long_cmp);
    armed_d  = armed_n & ~long_hit;

    res_o.stable_out    = stable_d;
    res_o.press_event   = rise;
    res_o.release_event = fall;
    res_o.short_event   = fall && (page_inc_cmp <= short_cmp);
    res_o.long_event    = long_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      active_q <= 1'b0;
      dage_q   <= '0;
      stable_q <= 1'b0;
      page_q   <= '0;
      armed_q  <= 1'b0;
    end else if (step_i) begin
      raw_q    <= raw_d;
      active_q <= active_d;
      dage_q   <= dage_d;
      stable_q <= stable_d;
      page_q   <= page_d;
      armed_q  <= armed_d;
    end
  end

endmodule

[hw/rtl/button_debounce_press_classifier_core.sv]
// An accepted request passes through the input register and then the result register to its result.
// Throughput: one request per cycle; a held result stalls the input register only when full.
// The tracking state updates once per request in a single pass of short logic.
// Reset: asynchronous, active low; clears the tracking state, both pipeline valids,
// and loads the configuration registers with their default limits (15, 1000, 3000).
module button_debounce_press_classifier_core #(
  parameter int unsigned AGE_WIDTH = bdpc_pkg::AgeWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             pin_level_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             stable_out_o,
  output logic                             press_event_o,
  output logic                             release_event_o,
  output logic                             short_event_o,
  output logic                             long_event_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bdpc_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [bdpc_pkg::CfgWidth-1:0]    cfg_data_i
);
  import bdpc_pkg::*;

  `include "button_debounce_press_classifier_core_assert.svh"

  cfg_t    cfg;
  result_t res_comb;
  result_t res_q;
  logic    in_valid_q, out_valid_q;
  logic    pin_q;
  logic    out_free, step, in_free;

  bdpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign step     = in_valid_q & out_free;
  assign in_free  = ~in_valid_q | out_free;
  assign in_stall_o = ~in_free;

  bdpc_track #(
    .AGE_WIDTH (AGE_WIDTH)
  ) u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .pin_i  (pin_q),
    .cfg_i  (cfg),
    .res_o  (res_comb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      pin_q <= pin_level_i;
    end
    if (step) begin
      res_q <= res_comb;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stable_out_o    = res_q.stable_out;
  assign press_event_o   = res_q.press_event;
  assign release_event_o = res_q.release_event;
  assign short_event_o   = res_q.short_event;
  assign long_event_o    = res_q.long_event;

  `BDPC_ASSERT_IMPL(a_press_high, clk_i, rst_ni, out_valid_o && press_event_o, stable_out_o)
  `BDPC_ASSERT_IMPL(a_release_low, clk_i, rst_ni, out_valid_o && release_event_o, !stable_out_o)
  `BDPC_ASSERT_IMPL(a_short_on_release, clk_i, rst_ni, out_valid_o && short_event_o, release_event_o)
  `BDPC_ASSERT_IMPL(a_long_held, clk_i, rst_ni, out_valid_o && long_event_o, stable_out_o)
  `BDPC_ASSERT_NEXT(a_step_fills, clk_i, rst_ni, step, out_valid_q)

endmodule

[tb/button_debounce_press_classifier_core_test.sv]
// Self-checking testbench for the button debounce and press classifier core.
module button_debounce_press_classifier_core_test;
  import bdpc_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam logic [CfgIdxWidth-1:0] CfgSpareIdx = 2'd3;
  localparam logic [CfgWidth-1:0] AgeMax = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic pin_level_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic stable_out_o;
  logic press_event_o;
  logic release_event_o;
  logic short_event_o;
  logic long_event_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [CfgWidth-1:0] cfg_data_i = '0;

  button_debounce_press_classifier_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .pin_level_i,
    .out_valid_o,
    .out_stall_i,
    .stable_out_o,
    .press_event_o,
    .release_event_o,
    .short_event_o,
    .long_event_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  logic [CfgWidth-1:0] lim_debounce = DebounceTicksRst;
  logic [CfgWidth-1:0] lim_short = ShortMaxTicksRst;
  logic [CfgWidth-1:0] lim_long = LongTicksRst;

  logic raw_level = 1'b0;
  logic settle_pending = 1'b0;
  logic [CfgWidth-1:0] settle_age = '0;
  logic debounced = 1'b0;
  logic [CfgWidth-1:0] held_age = '0;
  logic long_pending = 1'b0;

  logic pending_pins[$];
  result_t due_results[$];
  int failures = 0;
  int send_gap = 0;
  int take_wait = 0;
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;
  int idle_cycles = 0;

  function automatic result_t classify_tick(logic pin);
    result_t r;
    r = '0;
    settle_age = (settle_age == AgeMax) ? AgeMax : settle_age + 1'b1;
    held_age = (held_age == AgeMax) ? AgeMax : held_age + 1'b1;
    if (pin != raw_level) begin
      raw_level = pin;
      settle_pending = 1'b1;
      settle_age = '0;
    end
    if (settle_pending && settle_age >= lim_debounce) begin
      settle_pending = 1'b0;
      if (raw_level != debounced) begin
        debounced = raw_level;
        if (!debounced) begin
          r.release_event = 1'b1;
          r.short_event = (held_age <= lim_short);
          long_pending = 1'b0;
        end else begin
          r.press_event = 1'b1;
          long_pending = 1'b1;
          held_age = '0;
        end
      end
    end
    if (long_pending && held_age >= lim_long) begin
      r.long_event = 1'b1;
      long_pending = 1'b0;
    end
    r.stable_out = debounced;
    return r;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic check_bit(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s expected %0b actual %0b", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(classify_tick(pin_level_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_pins.size() > 0) begin
          in_valid_i <= 1'b1;
          pin_level_i <= pending_pins.pop_front();
          if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
          send_gap = draw_wait(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result with no pending request");
          failures++;
        end else begin
          want = due_results.pop_front();
          check_bit("stable_out", want.stable_out, stable_out_o);
          check_bit("press_event", want.press_event, press_event_o);
          check_bit("release_event", want.release_event, release_event_o);
          check_bit("short_event", want.short_event, short_event_o);
          check_bit("long_event", want.long_event, long_event_o);
        end
        if ($urandom_range(0, 63) == 0) take_calm = !take_calm;
        take_wait = draw_wait(take_calm);
      end
      if (take_wait > 0) begin
        take_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_limit(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DEBOUNCE_TICKS:  lim_debounce = value;
      CFG_SHORT_MAX_TICKS: lim_short = value;
      CFG_LONG_TICKS:      lim_long = value;
      default: ;
    endcase
  endtask

  task automatic write_limits(int deb, int sh, int lg);
    write_limit(CFG_DEBOUNCE_TICKS, deb[CfgWidth-1:0]);
    write_limit(CFG_SHORT_MAX_TICKS, sh[CfgWidth-1:0]);
    write_limit(CFG_LONG_TICKS, lg[CfgWidth-1:0]);
  endtask

  task automatic drain();
    while (pending_pins.size() > 0 || in_valid_i || due_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_level(logic lvl, int n);
    repeat (n) pending_pins.push_back(lvl);
  endtask

  task automatic push_noise(int n);
    repeat (n) pending_pins.push_back(1'($urandom_range(0, 1)));
  endtask

  initial begin
    int deb;
    int sh;
    int lg;
    int span;
    int target;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // glitches shorter than the default debounce window
    push_level(1'b0, 2);
    push_level(1'b1, 1);
    push_level(1'b0, 1);
    push_level(1'b1, 2);
    push_level(1'b0, 1);
    drain();

    // zero debounce: press, long, release without and with short
    write_limits(0, 1, 2);
    push_level(1'b1, 4);
    push_level(1'b0, 1);
    push_level(1'b1, 1);
    push_level(1'b0, 2);
    drain();

    // zero long and short limits: long fires together with press
    write_limits(0, 0, 0);
    push_level(1'b1, 1);
    push_level(1'b0, 1);
    push_level(1'b1, 2);
    push_level(1'b0, 2);
    drain();

    // release under the largest short and long limits
    write_limits(0, 65535, 65535);
    push_level(1'b1, 30);
    push_level(1'b0, 4);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      deb = $urandom_range(0, 6);
      sh = $urandom_range(0, 30);
      lg = $urandom_range(0, 50);
      if (ph == 2) lg = 0;
      if (ph == 3) begin
        deb = 0;
        sh = 0;
      end
      if (ph == 5) sh = 65535;
      if (ph == 6) deb = 65535;
      write_limits(deb, sh, lg);
      if (ph == 4) write_limit(CfgSpareIdx, 16'($urandom()));
      target = pending_pins.size() + ((ph == 6) ? 100 : 220);
      span = ((lg > sh) ? lg : sh) + 8;
      if (span > 80) span = 80;
      while (pending_pins.size() < target) begin
        if (ph == 6 || $urandom_range(0, 7) == 0) begin
          push_noise($urandom_range(1, 10));
        end else begin
          push_noise($urandom_range(0, deb + 1));
          push_level(1'b1, deb + 1 + $urandom_range(0, span));
          push_noise($urandom_range(0, deb + 1));
          push_level(1'b0, deb + 1 + $urandom_range(0, 10));
        end
      end
      drain();
    end

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
